FILE: hw/rtl/tfn_pkg.sv
// Shared types, latencies and floating-point rounding helpers for the face normal core.
package tfn_pkg;

	localparam int ADD_LAT  = 2;
	localparam int MUL_LAT  = 2;
	localparam int SQRT_LAT = 28;
	localparam int DIV_LAT  = 30;

	localparam logic [31:0] QNAN    = 32'h7FC0_0000;
	// 0.0001 in single precision.
	localparam logic [31:0] LEN_MIN = 32'h38D1_B717;

	typedef logic signed [11:0] exp_t;

	typedef struct packed {
		logic [31:0] vertex0_x;
		logic [31:0] vertex0_y;
		logic [31:0] vertex0_z;
		logic [31:0] vertex1_x;
		logic [31:0] vertex1_y;
		logic [31:0] vertex1_z;
		logic [31:0] vertex2_x;
		logic [31:0] vertex2_y;
		logic [31:0] vertex2_z;
	} tri_t;

	typedef struct packed {
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [31:0] normal_z;
	} nrm_t;

	function automatic logic [5:0] lzc48(input logic [47:0] x);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (x[i]) begin
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input logic [31:0] x);
		return (&x[30:23]) && (|x[22:0]);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (&x[30:23]) && !(|x[22:0]);
	endfunction

	// Rounds a significand m (leading one at bit 26, bit 0 sticky) worth m * 2^(e-153)
	// to nearest even and packs it, going subnormal or infinite where needed.
	function automatic logic [31:0] round_pack(input logic s, input exp_t e,
			input logic [26:0] m);
		logic [26:0] mm;
		logic [26:0] mask;
		exp_t        ee;
		exp_t        sh;
		logic [4:0]  sh5;
		logic [24:0] keep;
		logic        g;
		logic        st;
		mm   = m;
		ee   = e;
		mask = '0;
		sh   = '0;
		sh5  = '0;
		if (m == '0) begin
			return {s, 31'd0};
		end
		if (e < 12'sd1) begin
			sh = 12'sd1 - e;
			if (sh > 12'sd27) begin
				mm = {26'd0, 1'b1};
			end else begin
				sh5  = sh[4:0];
				mask = ~({27{1'b1}} << sh5);
				mm   = (m >> sh5) | {26'd0, |(m & mask)};
			end
			ee = 12'sd1;
		end
		keep = {1'b0, mm[26:3]};
		g    = mm[2];
		st   = |mm[1:0];
		if (g && (st || keep[0])) begin
			keep = keep + 25'd1;
		end
		if (keep[24]) begin
			keep = keep >> 1;
			ee   = ee + 12'sd1;
		end
		if (ee >= 12'sd255) begin
			return {s, 8'hFF, 23'd0};
		end
		return {s, (keep[23] ? ee[7:0] : 8'h00), keep[22:0]};
	endfunction

endpackage

FILE: hw/rtl/tfn_if.sv
// Valid/ready channel interfaces for triangles in and normals out.
interface tfn_tri_if;
	logic          valid;
	logic          ready;
	tfn_pkg::tri_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tfn_nrm_if;
	logic          valid;
	logic          ready;
	tfn_pkg::nrm_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/tfn_fadd.sv
// Two-stage single-precision adder: align, then add, normalize and round.
module tfn_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import tfn_pkg::*;

	logic        swp;
	logic [31:0] big;
	logic [31:0] sml;
	logic [7:0]  ebe;
	logic [7:0]  ese;
	logic [26:0] mbig;
	logic [26:0] msml;
	logic [7:0]  d;
	logic [26:0] mask;
	logic [26:0] al;
	logic        spec;
	logic [31:0] sval;

	logic        sb_s1;
	logic        ss_s1;
	exp_t        e_s1;
	logic [26:0] mbig_s1;
	logic [26:0] al_s1;
	logic        spec_s1;
	logic [31:0] sval_s1;

	logic [27:0] sum;
	logic [5:0]  lz;
	logic [26:0] mn;
	exp_t        en_e;
	logic [31:0] res;

	always_comb begin
		swp  = b[30:0] > a[30:0];
		big  = swp ? b : a;
		sml  = swp ? a : b;
		ebe  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		ese  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mbig = {big[30:23] != 8'd0, big[22:0], 3'b000};
		msml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		d    = ebe - ese;
		mask = '0;
		if (d > 8'd26) begin
			al = {26'd0, |msml};
		end else begin
			mask = ~({27{1'b1}} << d[4:0]);
			al   = (msml >> d[4:0]) | {26'd0, |(msml & mask)};
		end
		spec = 1'b1;
		sval = QNAN;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
			sval = QNAN;
		end else if (is_inf(a)) begin
			sval = a;
		end else if (is_inf(b)) begin
			sval = b;
		end else begin
			spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1   <= big[31];
			ss_s1   <= sml[31];
			e_s1    <= $signed({4'd0, ebe});
			mbig_s1 <= mbig;
			al_s1   <= al;
			spec_s1 <= spec;
			sval_s1 <= sval;
		end
	end

	always_comb begin
		if (sb_s1 != ss_s1) begin
			sum = {1'b0, mbig_s1} - {1'b0, al_s1};
		end else begin
			sum = {1'b0, mbig_s1} + {1'b0, al_s1};
		end
		lz   = lzc48({sum[26:0], 21'd0});
		mn   = sum[26:0] << lz;
		en_e = e_s1 - $signed({6'd0, lz});
		if (sum == '0) begin
			// An exact zero keeps its sign only when both operands carry it.
			res = {sb_s1 & ss_s1, 31'd0};
		end else if (sum[27]) begin
			res = round_pack(sb_s1, e_s1 + 12'sd1, sum[27:1] | {26'd0, sum[0]});
		end else begin
			res = round_pack(sb_s1, en_e, mn);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= spec_s1 ? sval_s1 : res;
		end
	end

endmodule

FILE: hw/rtl/tfn_fmul.sv
// Two-stage single-precision multiplier: product, then normalize and round.
module tfn_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import tfn_pkg::*;

	logic [23:0] ma;
	logic [23:0] mb;
	logic [7:0]  ea;
	logic [7:0]  eb;
	logic        sgn;
	logic        za;
	logic        zb;
	logic        spec;
	logic [31:0] sval;

	logic [47:0] p_s1;
	exp_t        e_s1;
	logic        s_s1;
	logic        spec_s1;
	logic [31:0] sval_s1;

	logic [5:0]  lz;
	logic [47:0] pn;
	exp_t        ex;

	always_comb begin
		ma   = {a[30:23] != 8'd0, a[22:0]};
		mb   = {b[30:23] != 8'd0, b[22:0]};
		ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		sgn  = a[31] ^ b[31];
		za   = (a[30:0] == 31'd0);
		zb   = (b[30:0] == 31'd0);
		spec = 1'b1;
		sval = QNAN;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && zb) || (is_inf(b) && za)) begin
			sval = QNAN;
		end else if (is_inf(a) || is_inf(b)) begin
			sval = {sgn, 8'hFF, 23'd0};
		end else if (za || zb) begin
			sval = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= {24'd0, ma} * {24'd0, mb};
			e_s1    <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
			s_s1    <= sgn;
			spec_s1 <= spec;
			sval_s1 <= sval;
		end
	end

	always_comb begin
		lz = lzc48(p_s1);
		pn = p_s1 << lz;
		ex = e_s1 - $signed({6'd0, lz});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= spec_s1 ? sval_s1
				: round_pack(s_s1, ex, pn[47:21] | {26'd0, |pn[20:0]});
		end
	end

endmodule

FILE: hw/rtl/tfn_fsqrt.sv
// Pipelined single-precision square root, one root bit per stage.
module tfn_fsqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x,
	output logic [31:0] y
);
	import tfn_pkg::*;

	localparam int NBITS = 26;

	typedef struct packed {
		logic [51:0] rad;
		logic [27:0] rem;
		logic [25:0] q;
		exp_t        e;
		logic        spec;
		logic [31:0] sval;
	} sq_t;

	sq_t         stg [NBITS+1];
	sq_t         in0;
	logic [23:0] m24;
	logic [23:0] mn;
	logic [5:0]  lz;
	exp_t        e;
	exp_t        ee;

	always_comb begin
		m24 = {x[30:23] != 8'd0, x[22:0]};
		lz  = lzc48({m24, 24'd0});
		mn  = m24 << lz;
		e   = $signed({4'd0, ((x[30:23] == 8'd0) ? 8'd1 : x[30:23])}) - 12'sd150
			- $signed({6'd0, lz});
		// The radicand exponent is made even so the root exponent is exact.
		if (e[0]) begin
			in0.rad = {1'b0, mn, 27'd0};
			ee      = e - 12'sd27;
		end else begin
			in0.rad = {mn, 28'd0};
			ee      = e - 12'sd28;
		end
		in0.rem  = '0;
		in0.q    = '0;
		in0.e    = (ee >>> 1) + 12'sd152;
		in0.spec = 1'b1;
		in0.sval = QNAN;
		if (is_nan(x)) begin
			in0.sval = QNAN;
		end else if (x[30:0] == 31'd0) begin
			in0.sval = x;
		end else if (x[31]) begin
			in0.sval = QNAN;
		end else if (is_inf(x)) begin
			in0.sval = x;
		end else begin
			in0.spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg[0] <= in0;
		end
	end

	for (genvar k = 0; k < NBITS; k++) begin : g_step
		logic [29:0] rw;
		logic [29:0] tr;
		sq_t         nx;

		always_comb begin
			nx = stg[k];
			rw = {stg[k].rem, stg[k].rad[51-2*k -: 2]};
			tr = {2'b00, stg[k].q, 2'b01};
			if (rw >= tr) begin
				nx.rem = 28'(rw - tr);
				nx.q   = {stg[k].q[24:0], 1'b1};
			end else begin
				nx.rem = rw[27:0];
				nx.q   = {stg[k].q[24:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg[k+1] <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= stg[NBITS].spec ? stg[NBITS].sval
				: round_pack(1'b0, stg[NBITS].e, {stg[NBITS].q, |stg[NBITS].rem});
		end
	end

endmodule

FILE: hw/rtl/tfn_fdiv.sv
// Pipelined single-precision divider, one quotient bit per stage.
module tfn_fdiv (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import tfn_pkg::*;

	localparam int NBITS = 28;

	typedef struct packed {
		logic [24:0] r;
		logic [27:0] q;
		logic [23:0] mb;
		exp_t        e;
		logic        s;
		logic        spec;
		logic [31:0] sval;
	} dv_t;

	dv_t         stg [NBITS+1];
	dv_t         in0;
	logic [23:0] ma;
	logic [23:0] mb;
	logic [5:0]  lza;
	logic [5:0]  lzb;
	logic        za;
	logic        zb;
	logic [27:0] qf;
	logic [26:0] mf;
	exp_t        ef;

	always_comb begin
		ma     = {a[30:23] != 8'd0, a[22:0]};
		mb     = {b[30:23] != 8'd0, b[22:0]};
		lza    = lzc48({ma, 24'd0});
		lzb    = lzc48({mb, 24'd0});
		za     = (a[30:0] == 31'd0);
		zb     = (b[30:0] == 31'd0);
		in0.r  = {1'b0, ma << lza};
		in0.q  = '0;
		in0.mb = mb << lzb;
		in0.s  = a[31] ^ b[31];
		in0.e  = ($signed({4'd0, ((a[30:23] == 8'd0) ? 8'd1 : a[30:23])})
			- $signed({6'd0, lza}))
			- ($signed({4'd0, ((b[30:23] == 8'd0) ? 8'd1 : b[30:23])})
			- $signed({6'd0, lzb}));
		in0.spec = 1'b1;
		in0.sval = QNAN;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b)) || (za && zb)) begin
			in0.sval = QNAN;
		end else if (is_inf(a) || zb) begin
			in0.sval = {in0.s, 8'hFF, 23'd0};
		end else if (za || is_inf(b)) begin
			in0.sval = {in0.s, 31'd0};
		end else begin
			in0.spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg[0] <= in0;
		end
	end

	for (genvar k = 0; k < NBITS; k++) begin : g_step
		logic [24:0] rs;
		dv_t         nx;

		always_comb begin
			nx = stg[k];
			// The first step decides the integer bit, the rest shift in fraction bits.
			rs = (k == 0) ? stg[k].r : (stg[k].r << 1);
			if (rs >= {1'b0, stg[k].mb}) begin
				nx.r = rs - {1'b0, stg[k].mb};
				nx.q = {stg[k].q[26:0], 1'b1};
			end else begin
				nx.r = rs;
				nx.q = {stg[k].q[26:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg[k+1] <= nx;
			end
		end
	end

	always_comb begin
		qf = stg[NBITS].q;
		if (qf[27]) begin
			mf = {qf[27:2], (|qf[1:0]) | (|stg[NBITS].r)};
			ef = stg[NBITS].e + 12'sd127;
		end else begin
			mf = {qf[26:1], qf[0] | (|stg[NBITS].r)};
			ef = stg[NBITS].e + 12'sd126;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= stg[NBITS].spec ? stg[NBITS].sval : round_pack(stg[NBITS].s, ef, mf);
		end
	end

endmodule

FILE: hw/rtl/triangle_face_normal_core.sv
// Top level: triangle in, unit face normal out, fully pipelined.
//
//   channel    role   payload
//   triangle   sink   nine single-precision vertex coordinates
//   normal     source three single-precision normal components
//
// One triangle is taken every cycle while no result is held at the output.
// The latency is set by the chain of float units: edge subtract, cross multiply and
// subtract, squares, two adds, a 28-stage square root and a 30-stage divider.
// All stages advance together; when a result is held at the output, the pipeline
// freezes and triangle.ready drops, so nothing is lost or repeated.
// Reset clears only the valid bits of the stages.
module triangle_face_normal_core (
	input  logic            clk,
	input  logic            arst_n,
	tfn_tri_if.sink         triangle,
	tfn_nrm_if.source       normal
);
	import tfn_pkg::*;

	localparam int LAT   = 4 * ADD_LAT + 2 * MUL_LAT + SQRT_LAT + DIV_LAT + 1;
	localparam int NDLY  = MUL_LAT + 2 * ADD_LAT + SQRT_LAT + DIV_LAT;
	localparam int NTAP  = MUL_LAT + 2 * ADD_LAT + SQRT_LAT - 1;

	logic                  en;
	logic [LAT-1:0]        vld_q;
	logic [2:0][31:0]      v0;
	logic [2:0][31:0]      v1;
	logic [2:0][31:0]      v2;
	logic [2:0][31:0]      ea;
	logic [2:0][31:0]      eb;
	logic [2:0][31:0]      pp;
	logic [2:0][31:0]      pr;
	logic [2:0][31:0]      n;
	logic [2:0][31:0]      sq;
	logic [2:0][31:0]      qt;
	logic [2:0][31:0]      sel;
	logic [2:0][31:0]      n_d [NDLY];
	logic [31:0]           sz_d [ADD_LAT];
	logic                  ok_d [DIV_LAT];
	logic [31:0]           s01;
	logic [31:0]           ssum;
	logic [31:0]           len;
	logic                  len_ok;

	assign en             = !normal.valid || normal.ready;
	assign triangle.ready = en;
	assign normal.valid   = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], triangle.valid};
		end
	end

	assign v0 = {triangle.data.vertex0_z, triangle.data.vertex0_y, triangle.data.vertex0_x};
	assign v1 = {triangle.data.vertex1_z, triangle.data.vertex1_y, triangle.data.vertex1_x};
	assign v2 = {triangle.data.vertex2_z, triangle.data.vertex2_y, triangle.data.vertex2_x};

	for (genvar i = 0; i < 3; i++) begin : g_axis
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		tfn_fadd u_ea (.clk, .en, .a(v1[i]), .b({~v0[i][31], v0[i][30:0]}), .y(ea[i]));
		tfn_fadd u_eb (.clk, .en, .a(v2[i]), .b({~v0[i][31], v0[i][30:0]}), .y(eb[i]));
		tfn_fmul u_pp (.clk, .en, .a(ea[J]), .b(eb[K]), .y(pp[i]));
		tfn_fmul u_pr (.clk, .en, .a(ea[K]), .b(eb[J]), .y(pr[i]));
		tfn_fadd u_n  (.clk, .en, .a(pp[i]), .b({~pr[i][31], pr[i][30:0]}), .y(n[i]));
		tfn_fmul u_sq (.clk, .en, .a(n[i]), .b(n[i]), .y(sq[i]));
		tfn_fdiv u_dv (.clk, .en, .a(n_d[NTAP][i]), .b(len), .y(qt[i]));
	end

	tfn_fadd  u_s01  (.clk, .en, .a(sq[0]), .b(sq[1]), .y(s01));
	tfn_fadd  u_ssum (.clk, .en, .a(s01), .b(sz_d[ADD_LAT-1]), .y(ssum));
	tfn_fsqrt u_sqrt (.clk, .en, .x(ssum), .y(len));

	// A NaN length fails the compare; positive floats order like their bit patterns.
	assign len_ok = !is_nan(len) && !len[31] && (len[30:0] > LEN_MIN[30:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			n_d[0]  <= n;
			sz_d[0] <= sq[2];
			ok_d[0] <= len_ok;
			for (int i = 1; i < NDLY; i++) begin
				n_d[i] <= n_d[i-1];
			end
			for (int i = 1; i < ADD_LAT; i++) begin
				sz_d[i] <= sz_d[i-1];
			end
			for (int i = 1; i < DIV_LAT; i++) begin
				ok_d[i] <= ok_d[i-1];
			end
		end
	end

	assign sel = ok_d[DIV_LAT-1] ? qt : n_d[NDLY-1];

	always_ff @(posedge clk) begin
		if (en) begin
			normal.data.normal_x <= sel[0];
			normal.data.normal_y <= sel[1];
			normal.data.normal_z <= sel[2];
		end
	end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the triangle face normal core.
`timescale 1ns / 100ps

module testbench;
	import tfn_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;
	logic running;

	tfn_tri_if tri_ch ();
	tfn_nrm_if nrm_ch ();

	triangle_face_normal_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.triangle(tri_ch),
		.normal(nrm_ch)
	);

	nrm_t expected_normals[$];
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   mismatches;
	int   triangles_sent;
	int   normals_checked;
	int   stall_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Single-precision value widened to a double; every float is exact in a double.
	function automatic real widen(input logic [31:0] b);
		real r;
		if (b[30:23] == 8'd0) begin
			r = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
			if (b[31]) begin
				r = -r;
			end
			return r;
		end
		return $bitstoreal({b[31], (b[30:23] == 8'hFF) ? 11'h7FF : 11'(b[30:23] + 11'd896),
			b[22:0], 29'd0});
	endfunction

	// Rounds a double to single precision, nearest even, keeping subnormals.
	// Double rounding through a 53-bit result is harmless for add, multiply,
	// divide and square root, so each float operation is done in double first.
	function automatic logic [31:0] narrow(input real x);
		logic [63:0] d;
		logic [63:0] mant;
		logic [63:0] keep;
		logic [63:0] rem;
		logic [63:0] half;
		int          fexp;
		int          sh;
		d = $realtobits(x);
		if (d[62:52] == 11'h7FF) begin
			return (d[51:0] != 0) ? QNAN : {d[63], 8'hFF, 23'd0};
		end
		if (d[62:52] == 11'd0) begin
			return {d[63], 31'd0};
		end
		fexp = int'(d[62:52]) - 1023 + 127;
		mant = {11'd0, 1'b1, d[51:0]};
		sh   = 29;
		if (fexp < 1) begin
			sh   = 29 + (1 - fexp);
			fexp = 0;
		end
		if (sh >= 64) begin
			return {d[63], 31'd0};
		end
		keep = mant >> sh;
		rem  = mant & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0])) begin
			keep = keep + 64'd1;
		end
		if (fexp == 0) begin
			return {d[63], 7'd0, keep[23], keep[22:0]};
		end
		if (keep[24]) begin
			keep = keep >> 1;
			fexp = fexp + 1;
		end
		if (fexp >= 255) begin
			return {d[63], 8'hFF, 23'd0};
		end
		return {d[63], 8'(fexp), keep[22:0]};
	endfunction

	function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
		return narrow(widen(a) - widen(b));
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		return narrow(widen(a) * widen(b));
	endfunction

	function automatic nrm_t face_normal(input tri_t t);
		logic [31:0] ax, ay, az, bx, by, bz, nx, ny, nz, sum, len;
		nrm_t        n;
		ax  = fsub(t.vertex1_x, t.vertex0_x);
		ay  = fsub(t.vertex1_y, t.vertex0_y);
		az  = fsub(t.vertex1_z, t.vertex0_z);
		bx  = fsub(t.vertex2_x, t.vertex0_x);
		by  = fsub(t.vertex2_y, t.vertex0_y);
		bz  = fsub(t.vertex2_z, t.vertex0_z);
		nx  = fsub(fmul(ay, bz), fmul(az, by));
		ny  = fsub(fmul(az, bx), fmul(ax, bz));
		nz  = fsub(fmul(ax, by), fmul(ay, bx));
		sum = narrow(widen(fmul(nx, nx)) + widen(fmul(ny, ny)));
		sum = narrow(widen(sum) + widen(fmul(nz, nz)));
		len = narrow($sqrt(widen(sum)));
		// A NaN length fails the comparison, so the raw product passes through.
		if (widen(len) > widen(LEN_MIN)) begin
			nx = narrow(widen(nx) / widen(len));
			ny = narrow(widen(ny) / widen(len));
			nz = narrow(widen(nz) / widen(len));
		end
		n.normal_x = narrow(widen(nx));
		n.normal_y = narrow(widen(ny));
		n.normal_z = narrow(widen(nz));
		return n;
	endfunction

	task automatic send_triangle(input tri_t t);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			tri_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tri_ch.valid <= 1'b1;
		tri_ch.data  <= t;
		do begin
			@(posedge clk);
		end while (!tri_ch.ready);
		expected_normals.insert(expected_normals.size(), face_normal(t));
		triangles_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		tri_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (expected_normals.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_coord(input int kind);
		logic [31:0] c;
		c = $urandom;
		case (kind)
			0: ;
			1: c[30:23] = 8'($urandom_range(136, 118));
			2: c[30:23] = 8'($urandom_range(104, 90));
			3: c[30:23] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			default: c[30:23] = 8'($urandom_range(254, 200));
		endcase
		return c;
	endfunction

	function automatic tri_t random_triangle();
		tri_t t;
		int   pick;
		int   kind;
		pick = $urandom_range(99);
		kind = (pick < 55) ? 1 : (pick < 70) ? 2 : (pick < 80) ? 0 : (pick < 88) ? 4 : 1;
		t.vertex0_x = random_coord(kind);
		t.vertex0_y = random_coord(kind);
		t.vertex0_z = random_coord(kind);
		t.vertex1_x = random_coord(kind);
		t.vertex1_y = random_coord(kind);
		t.vertex1_z = random_coord(kind);
		t.vertex2_x = random_coord(kind);
		t.vertex2_y = random_coord(kind);
		t.vertex2_z = random_coord(kind);
		// Repeated vertices give a zero-length product.
		if (pick >= 88 && pick < 95) begin
			if ($urandom_range(1) != 0) begin
				t.vertex2_x = t.vertex1_x;
				t.vertex2_y = t.vertex1_y;
				t.vertex2_z = t.vertex1_z;
			end else begin
				t.vertex1_x = t.vertex0_x;
				t.vertex1_y = t.vertex0_y;
				t.vertex1_z = t.vertex0_z;
			end
		end else if (pick >= 95) begin
			// Sprinkle infinities, NaNs and subnormals into otherwise sane triangles.
			case ($urandom_range(2))
				0: t.vertex0_x = random_coord(3);
				1: t.vertex1_y = random_coord(3);
				default: t.vertex2_z = random_coord(3);
			endcase
		end
		return t;
	endfunction

	function automatic tri_t make_triangle(input logic [31:0] c0x, c0y, c0z, c1x, c1y, c1z,
			c2x, c2y, c2z);
		tri_t t;
		t = '{c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z};
		return t;
	endfunction

	task automatic test_directed();
		// Right triangle in the xy plane and its mirror image.
		send_triangle(make_triangle(0, 0, 0, 32'h3F800000, 0, 0, 0, 32'h3F800000, 0));
		send_triangle(make_triangle(0, 0, 0, 0, 32'h3F800000, 0, 32'h3F800000, 0, 0));
		// All zero, negative zero and repeated vertices are degenerate.
		send_triangle('0);
		send_triangle({9{32'h80000000}});
		send_triangle(make_triangle(32'h40400000, 32'hC0000000, 32'h3F000000,
			32'h40400000, 32'hC0000000, 32'h3F000000, 32'h41200000, 0, 0));
		// Collinear points.
		send_triangle(make_triangle(0, 0, 0, 32'h3F800000, 32'h3F800000, 32'h3F800000,
			32'h40000000, 32'h40000000, 32'h40000000));
		// Small triangles whose length lands just around the threshold.
		send_triangle(make_triangle(0, 0, 0, 32'h3C23D70A, 0, 0, 0, 32'h3C23D70A, 0));
		send_triangle(make_triangle(0, 0, 0, 32'h3C23D70B, 0, 0, 0, 32'h3C23D70B, 0));
		send_triangle(make_triangle(0, 0, 0, 32'h3C23D709, 0, 0, 0, 32'h3C23D70A, 0));
		// Largest finite and very large coordinates, most overflowing into an infinite length.
		send_triangle(make_triangle(32'hFF7FFFFF, 0, 0, 32'h7F7FFFFF, 0, 0, 0, 32'h7F7FFFFF, 0));
		send_triangle({9{32'h7F7FFFFF}});
		send_triangle(make_triangle(0, 0, 0, 32'h5F000000, 0, 0, 0, 32'h5F000000, 0));
		// Infinities and NaNs in the coordinates.
		send_triangle(make_triangle(0, 0, 0, 32'h7F800000, 0, 0, 0, 32'h3F800000, 0));
		send_triangle(make_triangle(32'hFF800000, 0, 0, 0, 0, 0, 0, 0, 32'h7F800000));
		send_triangle(make_triangle(0, 0, 0, 32'h7FC00001, 0, 0, 0, 32'h3F800000, 0));
		send_triangle(make_triangle(32'hFFFFFFFF, 0, 0, 0, 32'h3F800000, 0, 0, 0, 0));
		send_triangle({9{32'hFFFFFFFF}});
		// Subnormal coordinates, including the smallest and largest.
		send_triangle(make_triangle(0, 0, 0, 32'h00000001, 0, 0, 0, 32'h80000001, 0));
		send_triangle(make_triangle(0, 0, 0, 32'h007FFFFF, 0, 0, 0, 32'h807FFFFF, 32'h00400000));
		send_triangle(make_triangle(32'h00000001, 0, 0, 32'h3F800000, 0, 0, 0, 32'h3F800000, 0));
		// Rounding-heavy values.
		send_triangle(make_triangle(32'h3F7FFFFF, 32'h3EAAAAAB, 32'hBF2AAAAB,
			32'h4B7FFFFF, 32'h33800001, 32'hC0490FDB, 32'h402DF854, 32'h3DCCCCCD, 32'h3F3504F3));
		send_triangle(make_triangle(32'h1F800000, 0, 0, 32'h1F800001, 32'h1F800000, 0,
			32'h1F800000, 0, 32'h1F800000));
		stop_sending();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_triangle(random_triangle());
		end
		stop_sending();
	endtask

	// Receiver side: ready changes at the falling edge.
	always @(negedge clk) begin
		if (running) begin
			nrm_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		nrm_t want;
		nrm_t got;
		if (running && nrm_ch.valid && nrm_ch.ready) begin
			got = nrm_ch.data;
			if (expected_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("Unexpected normal transfer: %h %h %h",
						got.normal_x, got.normal_y, got.normal_z);
				end
			end else begin
				want = expected_normals.pop_front();
				normals_checked++;
				if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
						got.normal_z !== want.normal_z) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Normal mismatch: expected %h %h %h, got %h %h %h",
							want.normal_x, want.normal_y, want.normal_z,
							got.normal_x, got.normal_y, got.normal_z);
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel completes a transfer.
	always @(posedge clk) begin
		if (!running || (tri_ch.valid && tri_ch.ready) || (nrm_ch.valid && nrm_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		running         = 1'b0;
		tri_ch.valid    = 1'b0;
		tri_ch.data     = '0;
		nrm_ch.ready    = 1'b0;
		tx_idle_pct     = 37;
		rx_idle_pct     = 88;
		mismatches      = 0;
		triangles_sent  = 0;
		normals_checked = 0;
		stall_cycles    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n  = 1'b1;
		running = 1'b1;

		test_directed();
		test_random(500);
		// Let the pipeline empty completely before the pace changes.
		wait_drained();
		tx_idle_pct = 88;
		rx_idle_pct = 37;
		test_random(550);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(550);

		wait_drained();
		repeat (150) @(posedge clk);
		$display("Sent %0d triangles and checked %0d normals, mismatches: %0d.",
			triangles_sent, normals_checked, mismatches);
		$display("Covered mesh-scale, tiny, degenerate, overflowing, NaN and subnormal input.");
		if (mismatches == 0 && expected_normals.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
